FILE: rtl/pvp_pkg.sv
// Shared types, widths and register codes for the perspective vertex projector.
package pvp_pkg;

	localparam int PVP_POINT_WIDTH = 24;
	localparam int DIR_W = 16;
	localparam int DIR_FRAC = 14;
	localparam int RATIO_BITS = 21;
	localparam int CAM_W = 24;
	localparam int VEC_W = 48;
	localparam int RES_W = 13;
	localparam int SCR_W = 20;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CAM_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOOK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HRES = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VRES = 3'd6;

	localparam logic [VEC_W-1:0] LOOK_RESET = 48'h0000_0000_4000;
	localparam logic [VEC_W-1:0] UP_RESET = 48'h4000_0000_0000;
	localparam logic [RES_W-1:0] HRES_RESET = 13'd640;
	localparam logic [RES_W-1:0] VRES_RESET = 13'd480;

	typedef logic signed [DIR_W-1:0] dir_t;

	typedef struct packed {
		dir_t [2:0] right;
		dir_t [2:0] vup;
		logic ok;
	} basis_t;

endpackage

FILE: rtl/perspective_vertex_project.sv
// Top level of the perspective vertex projector: configuration, vertex pipeline and output.
//
// Usage. A vertex word (point_x/y/z, signed Q16.8) is taken at each rising edge where start
// is high and busy is low. One result word (screen_x/y in signed Q16.4, visible) follows
// for every vertex, in order, on the cycle where done is high. done is a one-cycle strobe;
// the receiver has no way to hold results back and must take each word as it comes.
// The path is fully pipelined and takes one vertex per clock while busy is low (operand
// subtract, nine-lane dot product multiply, sums, ratio numerator multiply, a 22-stage
// divider per screen axis, then offset and clamp).
// Configuration goes in through cfg_valid/cfg_ready with a register index and data; ready
// is always high. Writes are only expected while no vertex is in flight. A write to the
// look or up vector restarts the camera basis unit, a sequential engine with one shared
// multiplier, a bit-per-cycle square root and bit-per-cycle divides; it keeps busy high
// until both basis vectors are normalized, or until the first or the second cross product
// comes out with zero length. Reset loads the default camera and starts the same basis
// computation, so busy is high after reset as well.
// Points behind the camera, at z of zero, or seen through a degenerate basis come out with
// visible low and zero coordinates.
module perspective_vertex_project #(
	parameter int POINT_WIDTH = pvp_pkg::PVP_POINT_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [POINT_WIDTH-1:0]     point_x,
	input  logic signed [POINT_WIDTH-1:0]     point_y,
	input  logic signed [POINT_WIDTH-1:0]     point_z,
	output logic                              done,
	output logic signed [pvp_pkg::SCR_W-1:0]  screen_x,
	output logic signed [pvp_pkg::SCR_W-1:0]  screen_y,
	output logic                              visible,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pvp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pvp_pkg::VEC_W-1:0]         cfg_data
);
	import pvp_pkg::*;

	// Relative coordinates, products, dot products and their magnitudes.
	localparam int REL_W = POINT_WIDTH + 1;
	localparam int PROD_W = POINT_WIDTH + 17;
	localparam int DW = POINT_WIDTH + 18;
	localparam int MW = POINT_WIDTH + 17;
	localparam int NUM_W = MW + 16;
	localparam int SUM_W = 24;

	// Configuration registers.
	logic [CAM_W-1:0] cam_x_q, cam_y_q, cam_z_q;
	logic [VEC_W-1:0] look_q, up_q;
	logic [RES_W-1:0] hres_q, vres_q;
	logic cfg_wr, kick;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign kick = cfg_wr && (cfg_index == REG_LOOK || cfg_index == REG_UP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			look_q <= LOOK_RESET;
			up_q <= UP_RESET;
			hres_q <= HRES_RESET;
			vres_q <= VRES_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_CAM_X: cam_x_q <= cfg_data[CAM_W-1:0];
				REG_CAM_Y: cam_y_q <= cfg_data[CAM_W-1:0];
				REG_CAM_Z: cam_z_q <= cfg_data[CAM_W-1:0];
				REG_LOOK: look_q <= cfg_data;
				REG_UP: up_q <= cfg_data;
				REG_HRES: hres_q <= cfg_data[RES_W-1:0];
				REG_VRES: vres_q <= cfg_data[RES_W-1:0];
				default: ;
			endcase
		end
	end

	// Camera basis, recomputed whenever the look or up vector changes.
	basis_t bas;
	logic   bas_busy;

	pvp_basis u_basis (
		.clk      (clk),
		.arst_n   (arst_n),
		.kick     (kick),
		.look_vec (look_q),
		.up_vec   (up_q),
		.basis    (bas),
		.busy     (bas_busy)
	);

	assign busy = bas_busy;

	logic accept;
	assign accept = start && !busy;

	// Camera position seen at the vertex width, as a signed value.
	logic signed [POINT_WIDTH-1:0] cam_x, cam_y, cam_z;
	assign cam_x = POINT_WIDTH'(cam_x_q);
	assign cam_y = POINT_WIDTH'(cam_y_q);
	assign cam_z = POINT_WIDTH'(cam_z_q);

	dir_t dir_r [3];
	dir_t dir_u [3];
	dir_t dir_l [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dir_r[i] = $signed(bas.right[i]);
			dir_u[i] = $signed(bas.vup[i]);
			dir_l[i] = $signed(look_q[16*i +: 16]);
		end
	end

	logic [15:0] h8, v8;
	assign h8 = {hres_q, 3'b000};
	assign v8 = {vres_q, 3'b000};

	// Stage 1: vertex relative to the camera.
	logic v_s1;
	logic signed [REL_W-1:0] rel_s1 [3];

	// Stage 2: the nine products of the three dot products.
	logic v_s2;
	logic signed [PROD_W-1:0] prod_s2 [9];

	// Stage 3: view-space x, y and z.
	logic v_s3;
	logic signed [DW-1:0] x_s3, y_s3, z_s3;

	// Stage 4: ratio numerators and the divisor.
	logic v_s4, vis_s4, negx_s4, negy_s4;
	logic [NUM_W-1:0] numx_s4, numy_s4;
	logic [MW-1:0] den_s4;

	logic [DW-1:0] ax, ay;
	logic zpos;
	logic capx, capy;

	// When |v| / z alone already reaches the ratio cap, the ratio saturates whatever the
	// resolution is, zero included. An all-ones numerator drives the divider to its cap.
	always_comb begin
		ax = x_s3[DW-1] ? -x_s3 : x_s3;
		ay = y_s3[DW-1] ? -y_s3 : y_s3;
		zpos = !z_s3[DW-1] && (z_s3 != '0);
		capx = DW'(ax[DW-1:RATIO_BITS]) >= $unsigned(z_s3);
		capy = DW'(ay[DW-1:RATIO_BITS]) >= $unsigned(z_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		rel_s1[0] <= REL_W'(point_x) - REL_W'(cam_x);
		rel_s1[1] <= REL_W'(point_y) - REL_W'(cam_y);
		rel_s1[2] <= REL_W'(point_z) - REL_W'(cam_z);

		for (int i = 0; i < 3; i++) begin
			prod_s2[i] <= rel_s1[i] * dir_r[i];
			prod_s2[3+i] <= rel_s1[i] * dir_u[i];
			prod_s2[6+i] <= rel_s1[i] * dir_l[i];
		end

		x_s3 <= DW'(prod_s2[0]) + DW'(prod_s2[1]) + DW'(prod_s2[2]);
		y_s3 <= DW'(prod_s2[3]) + DW'(prod_s2[4]) + DW'(prod_s2[5]);
		z_s3 <= DW'(prod_s2[6]) + DW'(prod_s2[7]) + DW'(prod_s2[8]);

		vis_s4 <= bas.ok && zpos;
		negx_s4 <= x_s3[DW-1];
		negy_s4 <= y_s3[DW-1];
		numx_s4 <= capx ? '1 : NUM_W'(h8) * NUM_W'(ax[MW-1:0]);
		numy_s4 <= capy ? '1 : NUM_W'(h8) * NUM_W'(ay[MW-1:0]);
		den_s4 <= z_s3[MW-1:0];
	end

	// Ratio dividers; the x lane carries the visibility and sign, the y lane its sign.
	logic dx_valid, dy_valid;
	logic [RATIO_BITS:0] dx_quot, dy_quot;
	logic [1:0] dx_side;
	logic dy_side;

	pvp_div_pipe #(
		.NUM_W  (NUM_W),
		.DEN_W  (MW),
		.Q_W    (RATIO_BITS),
		.SIDE_W (2)
	) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.num       (numx_s4),
		.den       (den_s4),
		.side_in   ({vis_s4, negx_s4}),
		.out_valid (dx_valid),
		.quot      (dx_quot),
		.side_out  (dx_side)
	);

	pvp_div_pipe #(
		.NUM_W  (NUM_W),
		.DEN_W  (MW),
		.Q_W    (RATIO_BITS),
		.SIDE_W (1)
	) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.num       (numy_s4),
		.den       (den_s4),
		.side_in   (negy_s4),
		.out_valid (dy_valid),
		.quot      (dy_quot),
		.side_out  (dy_side)
	);

	function automatic logic signed [SCR_W-1:0] clamp_scr(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi_lim;
		logic signed [SUM_W-1:0] lo_lim;
		hi_lim = 24'sd524287;
		lo_lim = -24'sd524288;
		if (v > hi_lim)
			return SCR_W'(hi_lim);
		else if (v < lo_lim)
			return SCR_W'(lo_lim);
		else
			return SCR_W'(v);
	endfunction

	// Output stage: apply the sign, add the screen center offset and saturate.
	logic signed [SUM_W-1:0] rx, ry, sum_x, sum_y;

	always_comb begin
		rx = dx_side[0] ? -$signed(SUM_W'(dx_quot)) : $signed(SUM_W'(dx_quot));
		ry = dy_side ? -$signed(SUM_W'(dy_quot)) : $signed(SUM_W'(dy_quot));
		sum_x = $signed(SUM_W'(h8)) + rx;
		sum_y = $signed(SUM_W'(v8)) + ry;
	end

	logic done_q, vis_q;
	logic signed [SCR_W-1:0] sx_q, sy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= dx_valid;
	end

	always_ff @(posedge clk) begin
		vis_q <= dx_side[1];
		sx_q <= dx_side[1] ? clamp_scr(sum_x) : '0;
		sy_q <= dx_side[1] ? clamp_scr(sum_y) : '0;
	end

	assign done = done_q;
	assign visible = vis_q;
	assign screen_x = sx_q;
	assign screen_y = sy_q;

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !visible |-> screen_x == '0 && screen_y == '0)
		else $error("hidden vertex with nonzero screen coordinates");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		dx_valid == dy_valid)
		else $error("divider lanes out of step");

	a_kick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		kick |=> busy)
		else $error("basis not recomputing after a direction write");

endmodule

FILE: rtl/pvp_basis.sv
// Sequential camera basis unit: two cross products, each normalized by a square root and divides.
module pvp_basis (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       kick,
	input  logic [pvp_pkg::VEC_W-1:0]  look_vec,
	input  logic [pvp_pkg::VEC_W-1:0]  up_vec,
	output pvp_pkg::basis_t            basis,
	output logic                       busy
);
	import pvp_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CROSS = 3'd1;
	localparam logic [2:0] ST_SQ    = 3'd2;
	localparam logic [2:0] ST_SQRT  = 3'd3;
	localparam logic [2:0] ST_DLOAD = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;

	logic [2:0] state_q;
	logic       phase_q;
	logic [4:0] cnt_q;
	logic [1:0] comp_q;
	logic       ok_q;

	logic signed [32:0] c_q [3];
	logic [63:0] acc_q, root_q, bit_q;
	logic [31:0] len_q, rem_q;
	logic [15:0] dvd_q, quo_q;
	dir_t right_q [3];
	dir_t vup_q [3];

	dir_t a_vec [3];
	dir_t b_vec [3];
	logic signed [32:0] op_a, op_b;
	logic signed [65:0] prod;
	logic signed [32:0] p33, c_cross, c_cur, c_sel, c_mag;
	logic [63:0] trial, root_n;
	logic        take;
	logic [32:0] t_div;
	logic        ge;
	logic [15:0] quo_next;
	logic [47:0] num;
	dir_t        dir_res;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			b_vec[i] = look_vec[16*i +: 16];
			a_vec[i] = phase_q ? right_q[i] : dir_t'(up_vec[16*i +: 16]);
		end
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		if (state_q == ST_SQ) begin
			unique case (cnt_q[1:0])
				2'd0: op_a = c_q[0];
				2'd1: op_a = c_q[1];
				default: op_a = c_q[2];
			endcase
			op_b = op_a;
		end else begin
			unique case (cnt_q[2:0])
				3'd0: begin op_a = 33'(a_vec[1]); op_b = 33'(b_vec[2]); end
				3'd1: begin op_a = 33'(a_vec[2]); op_b = 33'(b_vec[1]); end
				3'd2: begin op_a = 33'(a_vec[2]); op_b = 33'(b_vec[0]); end
				3'd3: begin op_a = 33'(a_vec[0]); op_b = 33'(b_vec[2]); end
				3'd4: begin op_a = 33'(a_vec[0]); op_b = 33'(b_vec[1]); end
				default: begin op_a = 33'(a_vec[1]); op_b = 33'(b_vec[0]); end
			endcase
		end
		prod = op_a * op_b;
		p33 = prod[32:0];
	end

	// Component under construction by the cross product sequence.
	always_comb begin
		unique case (cnt_q[2:1])
			2'd0: c_cur = c_q[0];
			2'd1: c_cur = c_q[1];
			default: c_cur = c_q[2];
		endcase
		c_cross = cnt_q[0] ? c_cur - p33 : p33;
	end

	always_comb begin
		trial = root_q + bit_q;
		take = acc_q >= trial;
		root_n = take ? (root_q >> 1) + bit_q : root_q >> 1;
	end

	always_comb begin
		unique case (comp_q)
			2'd0: c_sel = c_q[0];
			2'd1: c_sel = c_q[1];
			default: c_sel = c_q[2];
		endcase
		c_mag = c_sel[32] ? -c_sel : c_sel;
		num = 48'({c_mag[31:0], 14'b0}) + 48'(len_q >> 1);
		t_div = {rem_q, dvd_q[15]};
		ge = t_div >= {1'b0, len_q};
		quo_next = {quo_q[14:0], ge};
		dir_res = c_sel[32] ? dir_t'(-quo_next) : dir_t'(quo_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CROSS;
			phase_q <= 1'b0;
			cnt_q <= '0;
			comp_q <= '0;
			ok_q <= 1'b0;
		end else if (kick) begin
			state_q <= ST_CROSS;
			phase_q <= 1'b0;
			cnt_q <= '0;
			comp_q <= '0;
			ok_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CROSS: begin
					if (cnt_q == 5'd5) begin
						state_q <= ST_SQ;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_SQ: begin
					if (cnt_q == 5'd2) begin
						state_q <= ST_SQRT;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						comp_q <= '0;
						// A zero length vector leaves the basis unusable.
						state_q <= (root_n == '0) ? ST_IDLE : ST_DLOAD;
					end
				end
				ST_DLOAD: begin
					state_q <= ST_DIV;
					cnt_q <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						if (comp_q == 2'd2) begin
							cnt_q <= '0;
							if (!phase_q) begin
								phase_q <= 1'b1;
								state_q <= ST_CROSS;
							end else begin
								ok_q <= 1'b1;
								state_q <= ST_IDLE;
							end
						end else begin
							comp_q <= comp_q + 2'd1;
							state_q <= ST_DLOAD;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_CROSS: begin
				unique case (cnt_q[2:1])
					2'd0: c_q[0] <= c_cross;
					2'd1: c_q[1] <= c_cross;
					default: c_q[2] <= c_cross;
				endcase
			end
			ST_SQ: begin
				acc_q <= ((cnt_q == 5'd0) ? 64'd0 : acc_q) + prod[63:0];
				root_q <= '0;
				bit_q <= 64'd1 << 62;
			end
			ST_SQRT: begin
				if (take)
					acc_q <= acc_q - trial;
				root_q <= root_n;
				bit_q <= bit_q >> 2;
				len_q <= root_n[31:0];
			end
			ST_DLOAD: begin
				rem_q <= num[47:16];
				dvd_q <= num[15:0];
			end
			ST_DIV: begin
				rem_q <= ge ? 32'(t_div - {1'b0, len_q}) : t_div[31:0];
				dvd_q <= dvd_q << 1;
				quo_q <= quo_next;
				if (cnt_q == 5'd15) begin
					unique case ({phase_q, comp_q})
						3'b000: right_q[0] <= dir_res;
						3'b001: right_q[1] <= dir_res;
						3'b010: right_q[2] <= dir_res;
						3'b100: vup_q[0] <= dir_res;
						3'b101: vup_q[1] <= dir_res;
						default: vup_q[2] <= dir_res;
					endcase
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			basis.right[i] = right_q[i];
			basis.vup[i] = vup_q[i];
		end
		basis.ok = ok_q;
	end

	assign busy = (state_q != ST_IDLE);

endmodule

FILE: rtl/pvp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a capped quotient.
module pvp_div_pipe #(
	parameter int NUM_W = pvp_pkg::PVP_POINT_WIDTH + 33,
	parameter int DEN_W = pvp_pkg::PVP_POINT_WIDTH + 17,
	parameter int Q_W = pvp_pkg::RATIO_BITS,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [Q_W:0]      quot,
	output logic [SIDE_W-1:0] side_out
);
	localparam int HI_W = NUM_W - Q_W;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

	logic              v_s    [Q_W+1];
	logic              ovf_s  [Q_W+1];
	logic [DEN_W-1:0]  rem_s  [Q_W+1];
	logic [DEN_W-1:0]  den_s  [Q_W+1];
	logic [Q_W-1:0]    lo_s   [Q_W+1];
	logic [Q_W-1:0]    q_s    [Q_W+1];
	logic [SIDE_W-1:0] side_s [Q_W+1];

	logic [HI_W-1:0]   hi;
	logic              ovf0;
	logic [DEN_W:0]    t [Q_W];
	logic              ge [Q_W];

	// The quotient saturates when num / den reaches 2^Q_W.
	assign hi = num[NUM_W-1:Q_W];
	assign ovf0 = CMP_W'(hi) >= CMP_W'(den);

	always_comb begin
		for (int j = 0; j < Q_W; j++) begin
			t[j] = {rem_s[j], lo_s[j][Q_W-1]};
			ge[j] = t[j] >= {1'b0, den_s[j]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= Q_W; j++)
				v_s[j] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
			for (int j = 0; j < Q_W; j++)
				v_s[j+1] <= v_s[j];
		end
	end

	always_ff @(posedge clk) begin
		ovf_s[0] <= ovf0;
		rem_s[0] <= DEN_W'(hi);
		den_s[0] <= den;
		lo_s[0] <= num[Q_W-1:0];
		q_s[0] <= '0;
		side_s[0] <= side_in;
		for (int j = 0; j < Q_W; j++) begin
			ovf_s[j+1] <= ovf_s[j];
			rem_s[j+1] <= ge[j] ? DEN_W'(t[j] - {1'b0, den_s[j]}) : DEN_W'(t[j]);
			den_s[j+1] <= den_s[j];
			lo_s[j+1] <= lo_s[j] << 1;
			q_s[j+1] <= {q_s[j][Q_W-2:0], ge[j]};
			side_s[j+1] <= side_s[j];
		end
	end

	assign out_valid = v_s[Q_W];
	assign quot = ovf_s[Q_W] ? {1'b1, {Q_W{1'b0}}} : {1'b0, q_s[Q_W]};
	assign side_out = side_s[Q_W];

endmodule

FILE: verif/pvp_checker.sv
// Checker for the perspective vertex projector: shadows the registers, predicts and compares.
module pvp_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic signed [pvp_pkg::CAM_W-1:0]     point_x,
	input  logic signed [pvp_pkg::CAM_W-1:0]     point_y,
	input  logic signed [pvp_pkg::CAM_W-1:0]     point_z,
	input  logic                                 done,
	input  logic signed [pvp_pkg::SCR_W-1:0]     screen_x,
	input  logic signed [pvp_pkg::SCR_W-1:0]     screen_y,
	input  logic                                 visible,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [pvp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pvp_pkg::VEC_W-1:0]            cfg_data,
	output int                                   fails,
	output int                                   pending,
	output int                                   shown
);
	import pvp_pkg::*;

	typedef struct packed {
		logic signed [SCR_W-1:0] sx;
		logic signed [SCR_W-1:0] sy;
		logic                    vis;
	} screen_word_t;

	typedef longint vec3_t [3];

	logic signed [CAM_W-1:0] cam_x, cam_y, cam_z;
	logic [VEC_W-1:0]        look_reg, up_reg;
	logic [RES_W-1:0]        hres, vres;
	screen_word_t            screen_q [$];

	function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t c);
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] res, b;
		res = '0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Rounds each component to a Q2.14 unit vector; zero length reports failure.
	function automatic bit unit_vec(input vec3_t c, output vec3_t n);
		logic [63:0] s, m, len, q;
		s = '0;
		n = '{0, 0, 0};
		for (int i = 0; i < 3; i++) begin
			m = (c[i] < 0) ? -c[i] : c[i];
			s += m * m;
		end
		len = root_floor(s);
		if (len == 0) return 1'b0;
		for (int i = 0; i < 3; i++) begin
			m = (c[i] < 0) ? -c[i] : c[i];
			q = ((m << DIR_FRAC) + len / 2) / len;
			n[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic longint scaled_ratio(input longint v, input longint z, input longint m);
		logic [127:0] a, res, cap;
		cap = 128'd1 << RATIO_BITS;
		a = (v < 0) ? -v : v;
		if (a / z >= cap) begin
			res = cap;
		end else begin
			res = (a * m) / z;
			if (res > cap) res = cap;
		end
		return (v < 0) ? -longint'(res) : longint'(res);
	endfunction

	function automatic logic signed [SCR_W-1:0] clamp_screen(input longint v);
		if (v > 524287) v = 524287;
		if (v < -524288) v = -524288;
		return v[SCR_W-1:0];
	endfunction

	function automatic screen_word_t project(input logic signed [CAM_W-1:0] px,
			input logic signed [CAM_W-1:0] py, input logic signed [CAM_W-1:0] pz);
		vec3_t look, up, rc, rt, uc, vu, rel;
		longint x, y, z, h8;
		screen_word_t r;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			look[i] = longint'(dir_t'(look_reg[16*i +: 16]));
			up[i] = longint'(dir_t'(up_reg[16*i +: 16]));
		end
		rel[0] = longint'(px) - longint'(cam_x);
		rel[1] = longint'(py) - longint'(cam_y);
		rel[2] = longint'(pz) - longint'(cam_z);
		cross3(up, look, rc);
		if (!unit_vec(rc, rt)) return r;
		cross3(rt, look, uc);
		if (!unit_vec(uc, vu)) return r;
		x = 0;
		y = 0;
		z = 0;
		for (int i = 0; i < 3; i++) begin
			x += rel[i] * rt[i];
			y += rel[i] * vu[i];
			z += rel[i] * look[i];
		end
		if (z <= 0) return r;
		h8 = longint'(hres) * 8;
		r.sx = clamp_screen(h8 + scaled_ratio(x, z, h8));
		r.sy = clamp_screen(longint'(vres) * 8 + scaled_ratio(y, z, h8));
		r.vis = 1'b1;
		return r;
	endfunction

	assign pending = screen_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x <= '0;
			cam_y <= '0;
			cam_z <= '0;
			look_reg <= LOOK_RESET;
			up_reg <= UP_RESET;
			hres <= HRES_RESET;
			vres <= VRES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CAM_X: cam_x <= cfg_data[CAM_W-1:0];
				REG_CAM_Y: cam_y <= cfg_data[CAM_W-1:0];
				REG_CAM_Z: cam_z <= cfg_data[CAM_W-1:0];
				REG_LOOK: look_reg <= cfg_data;
				REG_UP: up_reg <= cfg_data;
				REG_HRES: hres <= cfg_data[RES_W-1:0];
				REG_VRES: vres <= cfg_data[RES_W-1:0];
				default: ;
			endcase
		end
	end

	// fails and shown start at zero as two-state integers.
	always @(posedge clk) begin
		screen_word_t want;
		if (arst_n && start && !busy) screen_q.push_back(project(point_x, point_y, point_z));
		if (arst_n && done) begin
			if (screen_q.size() == 0) begin
				$error("result word with no vertex outstanding");
				fails++;
			end else begin
				want = screen_q.pop_front();
				if (visible) shown++;
				if (screen_x !== want.sx) begin
					$error("screen_x expected %0d got %0d", want.sx, screen_x);
					fails++;
				end
				if (screen_y !== want.sy) begin
					$error("screen_y expected %0d got %0d", want.sy, screen_y);
					fails++;
				end
				if (visible !== want.vis) begin
					$error("visible expected %0d got %0d", want.vis, visible);
					fails++;
				end
			end
		end
	end

endmodule

FILE: verif/tb_perspective_vertex_project.sv
// Testbench top for the perspective vertex projector: stimulus, camera setup and verdict.
module tb_perspective_vertex_project;
	import pvp_pkg::*;

	// One vertex word goes in per accepted start; one screen word comes back per vertex.
	// The checker beside the block does all prediction and comparison.
	localparam int PIPE_CYCLES = 27;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_WORDS = 110;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic signed [CAM_W-1:0] point_x, point_y, point_z;
	logic                    done;
	logic signed [SCR_W-1:0] screen_x, screen_y;
	logic                    visible;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [VEC_W-1:0]        cfg_data;
	int                      fails, pending, shown;
	int                      sent;
	int                      cycles;
	bit                      no_gaps;

	perspective_vertex_project i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.done(done), .screen_x(screen_x), .screen_y(screen_y), .visible(visible),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pvp_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.done(done), .screen_x(screen_x), .screen_y(screen_y), .visible(visible),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .fails(fails), .pending(pending), .shown(shown)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The watchdog: a hung handshake must not run forever.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL perspective_vertex_project");
				$finish;
			end
		end
	end

	// Packs three Q2.14 direction components the way the look and up registers hold them.
	function automatic logic [VEC_W-1:0] dir3(input int dx, input int dy, input int dz);
		logic [15:0] a, b, c;
		a = dx[15:0];
		b = dy[15:0];
		c = dz[15:0];
		return {c, b, a};
	endfunction

	// Writes the whole camera. ready is looked at mid-cycle, where it is stable, so the
	// decision never races the block's own update at the edge. valid is only lowered
	// after the last register, so it never drops and rises in one step.
	task automatic set_camera(input logic [CAM_W-1:0] cx, input logic [CAM_W-1:0] cy,
			input logic [CAM_W-1:0] cz, input logic [VEC_W-1:0] look,
			input logic [VEC_W-1:0] up, input logic [RES_W-1:0] hr, input logic [RES_W-1:0] vr);
		logic [VEC_W-1:0] vals [7];
		bit taken;
		vals = '{VEC_W'(cx), VEC_W'(cy), VEC_W'(cz), look, up, VEC_W'(hr), VEC_W'(vr)};
		for (int i = 0; i < 7; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			do begin
				@(negedge clk);
				taken = cfg_ready;
				@(posedge clk);
			end while (!taken);
		end
		cfg_valid <= 1'b0;
	endtask

	// Presents one vertex word and holds it until the block takes it. start stays high
	// when no gap follows, so back-to-back words go in at full rate.
	task automatic send_vertex(input logic [CAM_W-1:0] px, input logic [CAM_W-1:0] py,
			input logic [CAM_W-1:0] pz);
		bit taken;
		int gap;
		start <= 1'b1;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		sent++;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lets every outstanding word come back and then idles on past that, so the next
	// camera write lands on an idle block.
	task automatic drain();
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (PIPE_CYCLES + 5) @(posedge clk);
	endtask

	// Mostly vertices near the camera, which land on or near the screen and exercise the
	// divide; the rest are anywhere in the world, mostly saturating or culled.
	task automatic random_vertex(input logic [CAM_W-1:0] cx, input logic [CAM_W-1:0] cy,
			input logic [CAM_W-1:0] cz);
		int span;
		if ($urandom_range(0, 9) < 7) begin
			span = 1 << $urandom_range(4, 18);
			send_vertex(cx + CAM_W'($urandom_range(0, 2 * span) - span),
				cy + CAM_W'($urandom_range(0, 2 * span) - span),
				cz + CAM_W'($urandom_range(0, 2 * span) - span));
		end else begin
			send_vertex(CAM_W'($urandom), CAM_W'($urandom), CAM_W'($urandom));
		end
	endtask

	initial begin
		logic [CAM_W-1:0] cx, cy, cz;
		logic [VEC_W-1:0] look, up;
		int n;
		arst_n = 1'b0;
		start = 1'b0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_CAM_X;
		cfg_data = '0;
		sent = 0;
		no_gaps = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Default camera at the origin looking along +x: a point straight ahead, one at
		// the camera itself (z of zero), one behind, the field extremes and a point far
		// off axis at tiny depth, where the ratio term caps and the output saturates.
		send_vertex(24'sd256, 24'sd0, 24'sd0);
		send_vertex(24'sd0, 24'sd0, 24'sd0);
		send_vertex(-24'sd256, 24'sd100, 24'sd100);
		send_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		send_vertex(24'h800000, 24'h800000, 24'h800000);
		send_vertex(24'h7FFFFF, 24'h800000, 24'h800000);
		send_vertex(24'sd1, 24'h7FFFFF, 24'h800000);
		send_vertex(24'sd1, 24'h800000, 24'h7FFFFF);
		send_vertex(24'sd1000, 24'sd37, -24'sd512);
		send_vertex(24'hFFFFFF, 24'sd0, 24'sd0);
		drain();

		// Extreme camera: corner positions and resolutions of 1 and 4096.
		set_camera(24'h800000, 24'h7FFFFF, 24'h000000, dir3(16384, 0, 0), dir3(0, 0, 16384),
			13'd4096, 13'd1);
		send_vertex(24'h7FFFFF, 24'h7FFFFF, 24'sd0);
		send_vertex(24'h800000, 24'h000000, 24'h7FFFFF);
		send_vertex(24'sd0, 24'h7FFFFF, 24'h800000);
		drain();
		set_camera(24'h7FFFFF, 24'h800000, 24'h800000, dir3(-32768, 32767, -32768),
			dir3(32767, 32767, 32767), 13'd1, 13'd4096);
		send_vertex(24'h800000, 24'h7FFFFF, 24'h7FFFFF);
		send_vertex(24'sd0, 24'sd0, 24'sd0);
		drain();

		// Degenerate bases: up parallel to look, then a zero look vector.
		set_camera(24'd0, 24'd0, 24'd0, dir3(0, 16384, 0), dir3(0, -8192, 0),
			13'd640, 13'd480);
		send_vertex(24'sd0, 24'sd512, 24'sd0);
		send_vertex(24'sd300, 24'sd512, 24'sd9);
		drain();
		set_camera(24'd0, 24'd0, 24'd0, '0, dir3(0, 0, 16384), 13'd800, 13'd600);
		send_vertex(24'sd512, 24'sd0, 24'sd0);
		drain();

		// Random cameras. Every third phase runs without gaps to stress full rate, and
		// partway through one phase the sender holds off until the pipeline is empty.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			no_gaps = (p % 3 == 1);
			cx = ($urandom_range(0, 3) == 0) ? CAM_W'($urandom) : CAM_W'($urandom_range(0, 4095));
			cy = ($urandom_range(0, 3) == 0) ? CAM_W'($urandom) : CAM_W'($urandom_range(0, 4095));
			cz = ($urandom_range(0, 3) == 0) ? CAM_W'($urandom) : CAM_W'($urandom_range(0, 4095));
			look = {$urandom, $urandom};
			up = {$urandom, $urandom};
			set_camera(cx, cy, cz, look, up, RES_W'($urandom_range(1, 4096)),
				RES_W'($urandom_range(1, 4096)));
			n = PHASE_WORDS;
			for (int i = 0; i < n; i++) begin
				random_vertex(cx, cy, cz);
				if (p == 2 && i == n / 2) begin
					// Step past the next edge first, so the word just taken is already counted.
					start <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
			end
			drain();
		end
		no_gaps = 1'b0;

		$display("Covered %0d vertex words over %0d camera setups; %0d came back visible.",
			sent, RANDOM_PHASES + 5, shown);
		if (fails == 0) begin
			$display("PASS perspective_vertex_project");
		end else begin
			$display("FAIL perspective_vertex_project");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/pvp_pkg.sv
rtl/pvp_basis.sv
rtl/pvp_div_pipe.sv
rtl/perspective_vertex_project.sv
verif/pvp_checker.sv
verif/tb_perspective_vertex_project.sv
